// File: design/slsh_pkg.sv
`timescale 1ns / 1ps
// shared widths, fixed-point constants, register codes and types for the steering search core
package slsh_pkg;

    // item field widths
    localparam int ELAPSED_W = 10;
    localparam int SPEED_W   = 15;
    localparam int MASK_W    = 4;
    localparam int LEVEL_W   = 16;
    localparam int CMD_W     = 17;
    localparam int DELAY_W   = 17;

    // datapath widths
    localparam int SPD_MAG_W   = 15;
    localparam int SPD_N_W     = 25;
    localparam int SPD_Q_W     = 18;
    localparam int ERR_W       = 19;
    localparam int E384_W      = 27;
    localparam int ADJ_W       = 25;
    localparam int LIMIT_W     = 17;
    localparam int LIMP_W      = 26;

    // cm/s to km/h Q8.8: round(m * 1152 / 125), divide by reciprocal
    localparam int SPD_RECIP_W = 26;
    localparam int SPD_PROD_W  = SPD_N_W + SPD_RECIP_W;
    localparam int SPD_SHIFT   = 32;
    localparam logic [SPD_RECIP_W-1:0] SPD_RECIP = 26'd34359739;
    localparam logic [SPD_N_W-1:0]     SPD_ROUND = 25'd62;

    // throttle rate limit: rate * dt / 1000
    localparam int LIM_RECIP_W = 27;
    localparam int LIM_PROD_W  = LIMP_W + LIM_RECIP_W;
    localparam int LIM_SHIFT   = 36;
    localparam logic [LIM_RECIP_W-1:0] LIM_RECIP = 27'd68719477;

    // proportional gain: |err| * 384 / 5
    localparam int ADJ_RECIP_W = 28;
    localparam int ADJ_PROD_W  = E384_W + ADJ_RECIP_W;
    localparam int ADJ_SHIFT   = 30;
    localparam logic [ADJ_RECIP_W-1:0] ADJ_RECIP = 28'd214748365;

    // 2 km/h in Q8.8
    localparam int AT_SPEED_BAND = 512;

    // configuration register codes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_TARGET   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RATE     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DELAY    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STEP_T   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_VALID_T  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STEER_ST = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INIT_ST  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_INVERT   = 3'd7;

    // register reset values
    localparam logic [LEVEL_W-1:0] RST_TARGET   = 16'd12800;
    localparam logic [LEVEL_W-1:0] RST_RATE     = 16'd32768;
    localparam logic [LEVEL_W-1:0] RST_DELAY    = 16'd1000;
    localparam logic [LEVEL_W-1:0] RST_STEP_T   = 16'd500;
    localparam logic [LEVEL_W-1:0] RST_VALID_T  = 16'd2000;
    localparam logic [LEVEL_W-1:0] RST_STEER_ST = 16'd655;
    localparam logic [LEVEL_W-1:0] RST_INIT_ST  = 16'd65535;

    // stage load enables from the top level handshake logic
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_stage_en;

    // control terms presented to the state update
    typedef struct packed {
        logic                 at_speed;
        logic                 adj_neg;
        logic [ADJ_W-1:0]     adj_mag;
        logic [LIMIT_W-1:0]   limit;
        logic [ELAPSED_W-1:0] dt;
        logic                 any_slip;
    } t_ctrl_term;

endpackage

// File: design/slsh_err_path.sv
`timescale 1ns / 1ps
// three-stage speed error, throttle adjustment and slew limit datapath
module slsh_err_path
    import slsh_pkg::*;
(
    input  logic                        i_clk,
    input  t_stage_en                   i_en,
    input  logic [ELAPSED_W-1:0]        i_dt,
    input  logic signed [SPEED_W-1:0]   i_cms,
    input  logic                        i_any_slip,
    input  logic [LEVEL_W-1:0]          i_target,
    input  logic [LEVEL_W-1:0]          i_rate,
    output t_ctrl_term                  o_term
);

    // stage 1: speed magnitude product and rate product
    logic                   spd_neg;
    logic [SPD_MAG_W-1:0]   spd_mag;
    logic [SPD_N_W-1:0]     spd_n;
    logic [SPD_PROD_W-1:0]  spd_prod;
    logic [LIMP_W-1:0]      lim_prod;

    logic [SPD_Q_W-1:0]     r1_q;
    logic                   r1_neg;
    logic [LIMP_W-1:0]      r1_limp;
    logic [ELAPSED_W-1:0]   r1_dt;
    logic                   r1_slip;

    assign spd_neg  = i_cms[SPEED_W-1];
    assign spd_mag  = spd_neg ? SPD_MAG_W'(-i_cms) : SPD_MAG_W'(i_cms);
    assign spd_n    = (SPD_N_W'(spd_mag) << 10) + (SPD_N_W'(spd_mag) << 7) + SPD_ROUND;
    assign spd_prod = SPD_PROD_W'(spd_n) * SPD_PROD_W'(SPD_RECIP);
    assign lim_prod = LIMP_W'(i_rate) * LIMP_W'(i_dt);

    always_ff @(posedge i_clk) begin
        if (i_en.ld1) begin
            r1_q    <= spd_prod[SPD_SHIFT +: SPD_Q_W];
            r1_neg  <= spd_neg;
            r1_limp <= lim_prod;
            r1_dt   <= i_dt;
            r1_slip <= i_any_slip;
        end
    end

    // stage 2: speed error, band check, gain pre-scale, slew limit
    logic signed [ERR_W-1:0] tgt_s;
    logic signed [ERR_W-1:0] q_s;
    logic signed [ERR_W-1:0] err;
    logic [ERR_W-1:0]        err_mag;
    logic [LIM_PROD_W-1:0]   lim_full;

    logic [E384_W-1:0]       r2_e384;
    logic                    r2_neg;
    logic                    r2_at;
    logic [LIMIT_W-1:0]      r2_limit;
    logic [ELAPSED_W-1:0]    r2_dt;
    logic                    r2_slip;

    assign tgt_s    = signed'(ERR_W'(i_target));
    assign q_s      = signed'(ERR_W'(r1_q));
    assign err      = r1_neg ? (tgt_s + q_s) : (tgt_s - q_s);
    assign err_mag  = err[ERR_W-1] ? unsigned'(-err) : unsigned'(err);
    assign lim_full = LIM_PROD_W'(r1_limp) * LIM_PROD_W'(LIM_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en.ld2) begin
            r2_e384  <= (E384_W'(err_mag) << 8) + (E384_W'(err_mag) << 7);
            r2_neg   <= err[ERR_W-1];
            r2_at    <= (err < signed'(ERR_W'(AT_SPEED_BAND)));
            r2_limit <= lim_full[LIM_SHIFT +: LIMIT_W];
            r2_dt    <= r1_dt;
            r2_slip  <= r1_slip;
        end
    end

    // stage 3: divide by five through reciprocal
    logic [ADJ_PROD_W-1:0] adj_full;
    t_ctrl_term            r3_term;

    assign adj_full = ADJ_PROD_W'(r2_e384) * ADJ_PROD_W'(ADJ_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en.ld3) begin
            r3_term.at_speed <= r2_at;
            r3_term.adj_neg  <= r2_neg;
            r3_term.adj_mag  <= adj_full[ADJ_SHIFT +: ADJ_W];
            r3_term.limit    <= r2_limit;
            r3_term.dt       <= r2_dt;
            r3_term.any_slip <= r2_slip;
        end
    end

    assign o_term = r3_term;

endmodule

// File: design/steering_limit_search_with_speed_hold_core.sv
`timescale 1ns / 1ps
// top level of the steering limit search core with proportional speed hold
//
// one control tick per stream transfer: each input transfer carries the tick length, forward
// speed and per-wheel skid and slip masks, and yields exactly one result transfer with the
// throttle, steering command, best validated steering, validated flag and at-speed flag.
// the block takes one transfer every clock cycle while results are taken; each input passes
// through the input register, three arithmetic stages, then the state update which doubles as
// the output register. the rate is set by the state update, the only loop. the arithmetic
// stages keep moving while a result waits on m_axis_tready, so up to four further transfers
// are taken before the input side stalls.
// configuration is written over the apb-style port, register i at byte address 4*i; write
// it only when no transfer is in flight. writing the start delay before control has begun
// reloads the delay countdown, and writing the initial steering reloads the steering level
module steering_limit_search_with_speed_hold_core
    import slsh_pkg::*;
#(
    parameter int WHEELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [9:0] elapsed_ms, [24:10] forward_speed_cms, [28:25] skid_mask, [32:29] slip_mask
    input  logic [39:0] s_axis_tdata,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] throttle_out, [32:16] steering_out, [48:33] best_steering, [49] validated,
    // [50] at_speed
    output logic [55:0] m_axis_tdata,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [LEVEL_W-1:0] r_target;
    logic [LEVEL_W-1:0] r_rate;
    logic [LEVEL_W-1:0] r_delay_cfg;
    logic [LEVEL_W-1:0] r_step_time;
    logic [LEVEL_W-1:0] r_valid_time;
    logic [LEVEL_W-1:0] r_steer_step;
    logic [LEVEL_W-1:0] r_init_steer;
    logic               r_invert;

    // controller state, also the result payload
    logic                      r_started;
    logic signed [DELAY_W-1:0] r_delay;
    logic [LEVEL_W-1:0]        r_throttle;
    logic [LEVEL_W-1:0]        r_steer;
    logic [CMD_W-1:0]          r_cmd;
    logic [LEVEL_W-1:0]        r_best;
    logic                      r_validated;
    logic [LEVEL_W-1:0]        r_val_t;
    logic [LEVEL_W-1:0]        r_step_t;
    logic                      r_o_at;

    // input register
    logic [ELAPSED_W-1:0]      r_in_dt;
    logic signed [SPEED_W-1:0] r_in_cms;
    logic                      r_in_slip;

    // pipeline occupancy
    logic r_v0, r_v1, r_v2, r_v3, r_ov;

    logic       s_accept;
    logic       fire;
    logic       rdy0, rdy1, rdy2, rdy3;
    t_stage_en  stage_en;
    t_ctrl_term term;

    logic                     cfg_wr;
    logic [REG_IDX_W-1:0]     cfg_idx;
    logic [MASK_W-1:0]        wheel_en;
    logic [MASK_W-1:0]        in_skid;
    logic [MASK_W-1:0]        in_slip;

    // -------- handshake: each stage loads when the one after it has room
    assign fire     = r_v3 && (!r_ov || m_axis_tready);
    assign rdy3     = !r_v3 || fire;
    assign stage_en.ld3 = r_v2 && rdy3;
    assign rdy2     = !r_v2 || stage_en.ld3;
    assign stage_en.ld2 = r_v1 && rdy2;
    assign rdy1     = !r_v1 || stage_en.ld2;
    assign stage_en.ld1 = r_v0 && rdy1;
    assign rdy0     = !r_v0 || stage_en.ld1;

    assign s_axis_tready = rdy0;
    assign s_accept      = s_axis_tvalid && rdy0;
    assign m_axis_tvalid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_v0 <= s_accept || (r_v0 && !stage_en.ld1);
            r_v1 <= stage_en.ld1 || (r_v1 && !stage_en.ld2);
            r_v2 <= stage_en.ld2 || (r_v2 && !stage_en.ld3);
            r_v3 <= stage_en.ld3 || (r_v3 && !fire);
            r_ov <= fire || (r_ov && !m_axis_tready);
        end
    end

    // -------- input register; only wheels that exist count
    genvar gi;
    generate
        for (gi = 0; gi < MASK_W; gi++) begin : g_wheel
            assign wheel_en[gi] = (gi < WHEELS);
        end
    endgenerate

    assign in_skid = s_axis_tdata[ELAPSED_W+SPEED_W +: MASK_W];
    assign in_slip = s_axis_tdata[ELAPSED_W+SPEED_W+MASK_W +: MASK_W];

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_dt   <= s_axis_tdata[0 +: ELAPSED_W];
            r_in_cms  <= signed'(s_axis_tdata[ELAPSED_W +: SPEED_W]);
            r_in_slip <= |((in_skid | in_slip) & wheel_en);
        end
    end

    // -------- arithmetic stages
    slsh_err_path u_err_path (
        .i_clk      (i_clk),
        .i_en       (stage_en),
        .i_dt       (r_in_dt),
        .i_cms      (r_in_cms),
        .i_any_slip (r_in_slip),
        .i_target   (r_target),
        .i_rate     (r_rate),
        .o_term     (term)
    );

    // -------- state update
    function automatic logic [LEVEL_W-1:0] sat_add(input logic [LEVEL_W-1:0] a,
                                                   input logic [ELAPSED_W-1:0] b);
        logic [LEVEL_W:0] s;
        s = (LEVEL_W+1)'(a) + (LEVEL_W+1)'(b);
        return s[LEVEL_W] ? {LEVEL_W{1'b1}} : s[LEVEL_W-1:0];
    endfunction

    logic [LIMIT_W-1:0]        adj_lim;
    logic [LEVEL_W+1:0]        thr_sum;
    logic [LEVEL_W-1:0]        thr_next;
    logic [LEVEL_W-1:0]        val_base;
    logic [LEVEL_W-1:0]        step_base;

    logic                      n_started;
    logic signed [DELAY_W-1:0] n_delay;
    logic [LEVEL_W-1:0]        n_throttle;
    logic [LEVEL_W-1:0]        n_steer;
    logic [CMD_W-1:0]          n_cmd;
    logic [LEVEL_W-1:0]        n_best;
    logic                      n_validated;
    logic [LEVEL_W-1:0]        n_val_t;
    logic [LEVEL_W-1:0]        n_step_t;
    logic                      n_o_at;

    // slew limit, then apply and clamp to the throttle range
    assign adj_lim = (term.adj_mag > ADJ_W'(term.limit)) ? term.limit
                                                         : term.adj_mag[LIMIT_W-1:0];
    assign thr_sum = (LEVEL_W+2)'(r_throttle) + (LEVEL_W+2)'(adj_lim);

    always_comb begin
        if (term.adj_neg) begin
            thr_next = (LIMIT_W'(r_throttle) >= adj_lim) ?
                       LEVEL_W'(LIMIT_W'(r_throttle) - adj_lim) : '0;
        end else begin
            thr_next = (thr_sum > (LEVEL_W+2)'({LEVEL_W{1'b1}})) ? {LEVEL_W{1'b1}}
                                                                  : thr_sum[LEVEL_W-1:0];
        end
    end

    always_comb begin
        n_started   = r_started;
        n_delay     = r_delay;
        n_throttle  = r_throttle;
        n_steer     = r_steer;
        n_cmd       = r_cmd;
        n_best      = r_best;
        n_validated = r_validated;
        n_val_t     = r_val_t;
        n_step_t    = r_step_t;
        n_o_at      = 1'b0;
        val_base    = r_val_t;
        step_base   = r_step_t;
        if (!r_started) begin
            // start delay countdown, no control on the tick that ends it
            n_delay   = r_delay - signed'(DELAY_W'(term.dt));
            n_started = (n_delay <= 0);
        end else begin
            n_throttle = thr_next;
            if (!term.at_speed) begin
                // off speed: both timers restart
                n_val_t  = '0;
                n_step_t = '0;
            end else begin
                n_o_at = 1'b1;
                if (term.any_slip) begin
                    val_base = '0;
                    if (r_step_t > r_step_time) begin
                        n_steer   = (r_steer > r_steer_step) ? (r_steer - r_steer_step) : '0;
                        step_base = '0;
                    end
                end else if (r_val_t > r_valid_time) begin
                    n_validated = 1'b1;
                    n_best      = r_steer;
                end
                n_cmd    = r_invert ? CMD_W'(-signed'(CMD_W'(n_steer))) : CMD_W'(n_steer);
                n_val_t  = sat_add(val_base, term.dt);
                n_step_t = sat_add(step_base, term.dt);
            end
        end
    end

    // -------- configuration write decode
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= RST_TARGET;
            r_rate       <= RST_RATE;
            r_delay_cfg  <= RST_DELAY;
            r_step_time  <= RST_STEP_T;
            r_valid_time <= RST_VALID_T;
            r_steer_step <= RST_STEER_ST;
            r_init_steer <= RST_INIT_ST;
            r_invert     <= 1'b0;
            r_started    <= 1'b0;
            r_delay      <= signed'(DELAY_W'(RST_DELAY));
            r_throttle   <= '0;
            r_steer      <= RST_INIT_ST;
            r_cmd        <= '0;
            r_best       <= '0;
            r_validated  <= 1'b0;
            r_val_t      <= '0;
            r_step_t     <= '0;
            r_o_at       <= 1'b0;
        end else begin
            if (fire) begin
                r_started   <= n_started;
                r_delay     <= n_delay;
                r_throttle  <= n_throttle;
                r_steer     <= n_steer;
                r_cmd       <= n_cmd;
                r_best      <= n_best;
                r_validated <= n_validated;
                r_val_t     <= n_val_t;
                r_step_t    <= n_step_t;
                r_o_at      <= n_o_at;
            end
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_TARGET:   r_target     <= pwdata[LEVEL_W-1:0];
                    REG_RATE:     r_rate       <= pwdata[LEVEL_W-1:0];
                    REG_DELAY: begin
                        r_delay_cfg <= pwdata[LEVEL_W-1:0];
                        // reload the countdown only before control has begun
                        if (!r_started) begin
                            r_delay <= signed'(DELAY_W'(pwdata[LEVEL_W-1:0]));
                        end
                    end
                    REG_STEP_T:   r_step_time  <= pwdata[LEVEL_W-1:0];
                    REG_VALID_T:  r_valid_time <= pwdata[LEVEL_W-1:0];
                    REG_STEER_ST: r_steer_step <= pwdata[LEVEL_W-1:0];
                    REG_INIT_ST: begin
                        r_init_steer <= pwdata[LEVEL_W-1:0];
                        r_steer      <= pwdata[LEVEL_W-1:0];
                    end
                    REG_INVERT:   r_invert     <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    // configuration read-back
    always_comb begin
        unique case (cfg_idx)
            REG_TARGET:   prdata = 32'(r_target);
            REG_RATE:     prdata = 32'(r_rate);
            REG_DELAY:    prdata = 32'(r_delay_cfg);
            REG_STEP_T:   prdata = 32'(r_step_time);
            REG_VALID_T:  prdata = 32'(r_valid_time);
            REG_STEER_ST: prdata = 32'(r_steer_step);
            REG_INIT_ST:  prdata = 32'(r_init_steer);
            REG_INVERT:   prdata = 32'(r_invert);
            default:      prdata = '0;
        endcase
    end

    // result payload straight from the state; it only moves when a new result is loaded into the state
    assign m_axis_tdata = {5'b0, r_o_at, r_validated, r_best, r_cmd, r_throttle};

`ifndef ASSERT_OFF
    // once validated, the flag stays set until reset
    a_validated_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_validated |=> r_validated)
        else $error("validated flag cleared");

    // at-speed can only be reported once control has begun
    a_at_speed_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_at |-> r_started)
        else $error("at_speed before start");

    // throttle stays at zero during the start delay
    a_throttle_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> (r_throttle == '0))
        else $error("throttle moved before start");

    // a held result must not see the controller state move underneath it
    a_state_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_axis_tready) |=> $stable(r_throttle) && $stable(r_best))
        else $error("state changed while result held");
`endif

endmodule
